// ===== sv/swcd_pkg.sv =====
package swcd_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_PAUSE = 2'd2,
    MODE_CD    = 2'd3
  } mode_t;

  localparam int unsigned DIV100_A_SHIFT = 26;
  localparam logic [19:0] DIV100_A_MUL   = 20'd671089;
  localparam int unsigned DIV100_B_SHIFT = 20;
  localparam logic [13:0] DIV100_B_MUL   = 14'd10486;
  localparam logic [6:0]  DIGIT_PAIR     = 7'd100;
  localparam logic [6:0]  SIXTY          = 7'd60;

  localparam logic [16:0] SW_MIN_LAST = 17'd71582;
  localparam logic [5:0]  SW_SEC_LAST = 6'd47;
  localparam logic [9:0]  SW_MS_LAST  = 10'd295;
  localparam logic [5:0]  SEC_MAX     = 6'd59;
  localparam logic [9:0]  MS_MAX      = 10'd999;

  typedef struct packed {
    logic       start_stop_level;
    logic       reset_level;
    logic       entry_valid;
    logic       entry_nonzero;
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } dec_t;

  typedef struct packed {
    logic        countdown_done;
    logic        pause_lamp;
    logic        run_lamp;
    logic [5:0]  cd_seconds;
    logic [5:0]  cd_minutes;
    logic [6:0]  cd_hours;
    logic [9:0]  sw_millis;
    logic [5:0]  sw_seconds;
    logic [16:0] sw_minutes;
    mode_t       mode;
  } res_t;

endpackage

// ===== sv/swcd_decode.sv =====
module swcd_decode
  import swcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_ss,
  input  logic        in_rst,
  input  logic        in_ev,
  input  logic [19:0] in_val,
  output logic        dec_valid,
  input  logic        dec_ready,
  output dec_t        dec
);

  typedef struct packed {
    logic ss;
    logic rst;
    logic ev;
    logic nz;
  } btn_t;

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        rdy1, rdy2, rdy3, rdy4;

  btn_t        b1_r, b2_r, b3_r;
  logic [19:0] val1_r, val2_r;
  logic [13:0] q2_r, q3_r;
  logic [6:0]  h3_r, s3_r;
  dec_t        dec_r;

  logic [39:0] prod_a;
  logic [13:0] q100;
  logic [27:0] prod_b;
  logic [19:0] sec_full;
  logic [13:0] min_full;
  logic [6:0]  min_raw;
  logic [6:0]  sec_adj;
  logic [6:0]  min_sum;
  logic [6:0]  min_adj;
  logic        sec_carry, min_carry;
  dec_t        dec_nxt;

  assign rdy4     = ~v4_r | dec_ready;
  assign rdy3     = ~v3_r | rdy4;
  assign rdy2     = ~v2_r | rdy3;
  assign rdy1     = ~v1_r | rdy2;
  assign in_ready = rdy1;

  assign prod_a = 40'(val1_r) * 40'(DIV100_A_MUL);
  assign q100   = prod_a[DIV100_A_SHIFT +: 14];

  assign prod_b   = 28'(q2_r) * 28'(DIV100_B_MUL);
  assign sec_full = val2_r - 20'(q2_r) * 20'(DIGIT_PAIR);

  assign min_full  = q3_r - 14'(h3_r) * 14'(DIGIT_PAIR);
  assign min_raw   = min_full[6:0];
  assign sec_carry = (s3_r >= SIXTY);
  assign sec_adj   = sec_carry ? s3_r - SIXTY : s3_r;
  assign min_sum   = min_raw + 7'(sec_carry);
  assign min_carry = (min_sum >= SIXTY);
  assign min_adj   = min_carry ? min_sum - SIXTY : min_sum;

  always_comb begin
    dec_nxt.start_stop_level = b3_r.ss;
    dec_nxt.reset_level      = b3_r.rst;
    dec_nxt.entry_valid      = b3_r.ev;
    dec_nxt.entry_nonzero    = b3_r.nz;
    dec_nxt.hours            = h3_r + 7'(min_carry);
    dec_nxt.minutes          = min_adj[5:0];
    dec_nxt.seconds          = sec_adj[5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      b1_r   <= '{ss: in_ss, rst: in_rst, ev: in_ev, nz: (in_val != 20'd0)};
      val1_r <= in_val;
    end
    if (rdy2 && v1_r) begin
      b2_r   <= b1_r;
      val2_r <= val1_r;
      q2_r   <= q100;
    end
    if (rdy3 && v2_r) begin
      b3_r <= b2_r;
      q3_r <= q2_r;
      h3_r <= prod_b[DIV100_B_SHIFT +: 7];
      s3_r <= sec_full[6:0];
    end
    if (rdy4 && v3_r) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec_valid = v4_r;
  assign dec       = dec_r;

endmodule

// ===== sv/swcd_core.sv =====
module swcd_core
  import swcd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic dec_valid,
  output logic dec_ready,
  input  dec_t dec,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  mode_t       mode_r, mode_nxt;
  logic        last_r;
  logic [16:0] swm_r, swm_nxt;
  logic [5:0]  sws_r, sws_nxt;
  logic [9:0]  swms_r, swms_nxt;
  logic [6:0]  cdh_r, cdh_nxt;
  logic [5:0]  cdm_r, cdm_nxt;
  logic [5:0]  cds_r, cds_nxt;
  logic [9:0]  cdms_r, cdms_nxt;
  logic        run_r, run_nxt;
  logic        pause_r, pause_nxt;
  logic        done;
  logic        btn_edge;
  logic        take;
  logic        res_valid_r;
  res_t        res_r;

  assign dec_ready = ~res_valid_r | res_ready;
  assign take      = dec_valid & dec_ready;
  assign btn_edge  = last_r & ~dec.start_stop_level;

  always_comb begin
    mode_nxt  = mode_r;
    swm_nxt   = swm_r;
    sws_nxt   = sws_r;
    swms_nxt  = swms_r;
    cdh_nxt   = cdh_r;
    cdm_nxt   = cdm_r;
    cds_nxt   = cds_r;
    cdms_nxt  = cdms_r;
    run_nxt   = run_r;
    pause_nxt = pause_r;
    done      = 1'b0;
    if (!dec.reset_level) begin
      mode_nxt = MODE_IDLE;
      cdh_nxt  = '0;
      cdm_nxt  = '0;
      cds_nxt  = '0;
      cdms_nxt = '0;
    end else begin
      case (mode_r)
        MODE_IDLE: begin
          if (btn_edge) begin
            mode_nxt = MODE_RUN;
            swm_nxt  = '0;
            sws_nxt  = '0;
            swms_nxt = '0;
          end else if (dec.entry_valid && dec.entry_nonzero) begin
            mode_nxt = MODE_CD;
            cdh_nxt  = dec.hours;
            cdm_nxt  = dec.minutes;
            cds_nxt  = dec.seconds;
            cdms_nxt = '0;
          end
        end
        MODE_RUN: begin
          if (swm_r == SW_MIN_LAST && sws_r == SW_SEC_LAST && swms_r == SW_MS_LAST) begin
            swm_nxt  = '0;
            sws_nxt  = '0;
            swms_nxt = '0;
          end else if (swms_r != MS_MAX) begin
            swms_nxt = swms_r + 10'd1;
          end else begin
            swms_nxt = '0;
            if (sws_r != SEC_MAX) begin
              sws_nxt = sws_r + 6'd1;
            end else begin
              sws_nxt = '0;
              swm_nxt = swm_r + 17'd1;
            end
          end
          if (btn_edge) mode_nxt = MODE_PAUSE;
        end
        MODE_PAUSE: begin
          if (btn_edge) mode_nxt = MODE_RUN;
        end
        default: begin
          if (cdms_r == '0 && cdh_r == '0 && cdm_r == '0 && cds_r == 6'd1) begin
            done     = 1'b1;
            mode_nxt = MODE_IDLE;
            cdh_nxt  = '0;
            cdm_nxt  = '0;
            cds_nxt  = '0;
            cdms_nxt = '0;
          end else if (cdms_r != '0) begin
            cdms_nxt = cdms_r - 10'd1;
          end else begin
            cdms_nxt = MS_MAX;
            if (cds_r != '0) begin
              cds_nxt = cds_r - 6'd1;
            end else begin
              cds_nxt = SEC_MAX;
              if (cdm_r != '0) begin
                cdm_nxt = cdm_r - 6'd1;
              end else begin
                cdm_nxt = SEC_MAX;
                cdh_nxt = cdh_r - 7'd1;
              end
            end
          end
        end
      endcase
      if (mode_nxt == MODE_RUN) begin
        run_nxt   = 1'b1;
        pause_nxt = 1'b0;
      end else if (mode_nxt == MODE_PAUSE) begin
        run_nxt   = 1'b0;
        pause_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      last_r      <= 1'b1;
      swm_r       <= '0;
      sws_r       <= '0;
      swms_r      <= '0;
      cdh_r       <= '0;
      cdm_r       <= '0;
      cds_r       <= '0;
      cdms_r      <= '0;
      run_r       <= 1'b0;
      pause_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (take) begin
        mode_r  <= mode_nxt;
        last_r  <= dec.start_stop_level;
        swm_r   <= swm_nxt;
        sws_r   <= sws_nxt;
        swms_r  <= swms_nxt;
        cdh_r   <= cdh_nxt;
        cdm_r   <= cdm_nxt;
        cds_r   <= cds_nxt;
        cdms_r  <= cdms_nxt;
        run_r   <= run_nxt;
        pause_r <= pause_nxt;
      end
      if (dec_ready) res_valid_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r.mode           <= mode_nxt;
      res_r.sw_minutes     <= swm_nxt;
      res_r.sw_seconds     <= sws_nxt;
      res_r.sw_millis      <= swms_nxt;
      res_r.cd_hours       <= cdh_nxt;
      res_r.cd_minutes     <= cdm_nxt;
      res_r.cd_seconds     <= cds_nxt;
      res_r.run_lamp       <= run_nxt;
      res_r.pause_lamp     <= pause_nxt;
      res_r.countdown_done <= done;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== sv/stopwatch_and_countdown_timer.sv =====
// Stopwatch and countdown timer, one word per millisecond tick. A word is taken on
// every cycle the pipeline has room. It passes an input register, three stages that
// split the HHMMSS entry into hours, minutes and seconds with constant reciprocal
// multiplies, and one stage that updates the timer state and loads the output
// register, which presents the result. A stalled output holds the result and
// backs up the pipeline. Elapsed time is kept as minute, second and millisecond
// counters and remaining time as hour, minute, second and millisecond counters, so
// the display fields come straight from the state.
module stopwatch_and_countdown_timer
  import swcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // start_stop_level[0], reset_level[1], entry_valid[2], entry_value[22:3], zero[23]
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // mode[1:0], sw_minutes[18:2], sw_seconds[24:19], sw_millis[34:25],
  // cd_hours[41:35], cd_minutes[47:42], cd_seconds[53:48], run_lamp[54],
  // pause_lamp[55], countdown_done[56], zero[63:57]
  output logic [63:0] out_tdata
);

  logic dec_valid, dec_ready;
  dec_t dec;
  res_t res;

  swcd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_ss     (in_tdata[0]),
    .in_rst    (in_tdata[1]),
    .in_ev     (in_tdata[2]),
    .in_val    (in_tdata[22:3]),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec)
  );

  swcd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {7'd0, res};

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.countdown_done |->
      res.mode == MODE_IDLE && res.cd_hours == '0 && res.cd_minutes == '0 &&
      res.cd_seconds == '0)
    else $error("countdown end without idle and cleared time");

  a_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.mode == MODE_RUN || res.mode == MODE_PAUSE) |->
      res.run_lamp == (res.mode == MODE_RUN) && res.pause_lamp == (res.mode == MODE_PAUSE))
    else $error("lamps disagree with mode");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.sw_seconds <= SEC_MAX && res.sw_millis <= MS_MAX &&
      res.cd_minutes <= SEC_MAX && res.cd_seconds <= SEC_MAX)
    else $error("time field out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

endmodule

// ===== dv/stopwatch_and_countdown_timer_tb.sv =====
`timescale 1ns / 1ps

module stopwatch_and_countdown_timer_tb;
  import swcd_pkg::*;

  localparam int unsigned TICK_ITEMS   = 410;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  class timer_scoreboard;
    mode_t       mode_q;
    bit          last_btn;
    bit   [31:0] elapsed_ms;
    bit   [28:0] remaining_ms;
    bit          run_lamp_q;
    bit          pause_lamp_q;
    res_t        pending_results[$];
    int unsigned n_errors;
    int unsigned n_results;

    function new();
      mode_q       = MODE_IDLE;
      last_btn     = 1'b1;
      elapsed_ms   = '0;
      remaining_ms = '0;
      run_lamp_q   = 1'b0;
      pause_lamp_q = 1'b0;
      n_errors     = 0;
      n_results    = 0;
    endfunction

    function void note_tick(logic [23:0] word);
      logic        ss;
      logic        rst_lvl;
      logic        ev;
      int unsigned val;
      int unsigned secs;
      bit          press;
      bit          done;
      res_t        r;
      ss      = word[0];
      rst_lvl = word[1];
      ev      = word[2];
      val     = 32'(word[22:3]);
      press   = last_btn && !ss;
      done    = 1'b0;
      last_btn = ss;
      if (!rst_lvl) begin
        mode_q       = MODE_IDLE;
        remaining_ms = '0;
      end else begin
        case (mode_q)
          MODE_IDLE: begin
            if (press) begin
              mode_q     = MODE_RUN;
              elapsed_ms = '0;
            end else if (ev && val != 0) begin
              secs = (val / 10000) * 3600 + ((val / 100) % 100) * 60 + val % 100;
              remaining_ms = 29'(secs * 1000);
              mode_q = MODE_CD;
            end
          end
          MODE_RUN: begin
            elapsed_ms = elapsed_ms + 1;
            if (press) mode_q = MODE_PAUSE;
          end
          MODE_PAUSE: begin
            if (press) mode_q = MODE_RUN;
          end
          default: begin
            if (remaining_ms != 0) remaining_ms = remaining_ms - 29'd1;
            if (remaining_ms < 1000) begin
              remaining_ms = '0;
              mode_q       = MODE_IDLE;
              done         = 1'b1;
            end
          end
        endcase
        if (mode_q == MODE_RUN) begin
          run_lamp_q   = 1'b1;
          pause_lamp_q = 1'b0;
        end else if (mode_q == MODE_PAUSE) begin
          run_lamp_q   = 1'b0;
          pause_lamp_q = 1'b1;
        end
      end
      r.mode           = mode_q;
      r.sw_minutes     = 17'(elapsed_ms / 60000);
      r.sw_seconds     = 6'((elapsed_ms / 1000) % 60);
      r.sw_millis      = 10'(elapsed_ms % 1000);
      r.cd_hours       = 7'(remaining_ms / 3600000);
      r.cd_minutes     = 6'((remaining_ms / 60000) % 60);
      r.cd_seconds     = 6'((remaining_ms / 1000) % 60);
      r.run_lamp       = run_lamp_q;
      r.pause_lamp     = pause_lamp_q;
      r.countdown_done = done;
      pending_results.push_back(r);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(logic [63:0] word);
      res_t want;
      res_t got;
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word expected none got %h", $time, word);
        n_errors++;
        return;
      end
      want = pending_results.pop_front();
      got  = res_t'(word[56:0]);
      cmp_field("mode", 32'(want.mode), 32'(got.mode));
      cmp_field("sw_minutes", 32'(want.sw_minutes), 32'(got.sw_minutes));
      cmp_field("sw_seconds", 32'(want.sw_seconds), 32'(got.sw_seconds));
      cmp_field("sw_millis", 32'(want.sw_millis), 32'(got.sw_millis));
      cmp_field("cd_hours", 32'(want.cd_hours), 32'(got.cd_hours));
      cmp_field("cd_minutes", 32'(want.cd_minutes), 32'(got.cd_minutes));
      cmp_field("cd_seconds", 32'(want.cd_seconds), 32'(got.cd_seconds));
      cmp_field("run_lamp", 32'(want.run_lamp), 32'(got.run_lamp));
      cmp_field("pause_lamp", 32'(want.pause_lamp), 32'(got.pause_lamp));
      cmp_field("countdown_done", 32'(want.countdown_done), 32'(got.countdown_done));
      cmp_field("pad", 0, 32'(word[63:57]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // start_stop_level[0], reset_level[1], entry_valid[2], entry_value[22:3], zero[23]
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // mode[1:0], sw_minutes[18:2], sw_seconds[24:19], sw_millis[34:25],
  // cd_hours[41:35], cd_minutes[47:42], cd_seconds[53:48], run_lamp[54],
  // pause_lamp[55], countdown_done[56], zero[63:57]
  logic [63:0] out_tdata;

  timer_scoreboard sb;
  int unsigned     words_sent  = 0;
  int unsigned     idle_cycles = 0;
  bit              held_off    = 1'b0;

  always #5 clk = ~clk;

  stopwatch_and_countdown_timer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [19:0] rand_entry();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 20'd1;
    if (r < 70) return 20'($urandom_range(0, 99));
    return 20'($urandom);
  endfunction

  task automatic send_tick(input logic ss, input logic rst_lvl, input logic ev,
                           input logic [19:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, val, ev, rst_lvl, ss};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_tick({1'b0, val, ev, rst_lvl, ss});
    words_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("FAIL stopwatch_and_countdown_timer");
    $finish;
  end

  initial begin : rx
    int unsigned gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held_off && sb.n_results >= 120) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stim
    int unsigned base;
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero entry, one-second countdown, huge entry with edges and entries ignored
    send_tick(1'b1, 1'b1, 1'b1, 20'd0);
    send_tick(1'b1, 1'b1, 1'b1, 20'd1);
    send_tick(1'b1, 1'b1, 1'b0, 20'd0);
    send_tick(1'b1, 1'b1, 1'b1, 20'hFFFFF);
    send_tick(1'b0, 1'b1, 1'b0, 20'd0);
    send_tick(1'b1, 1'b1, 1'b1, 20'd5);
    send_tick(1'b1, 1'b0, 1'b0, 20'd0);
    // edge beats entry, run, pause, resume
    send_tick(1'b0, 1'b1, 1'b1, 20'd999999);
    send_tick(1'b0, 1'b1, 1'b0, 20'd0);
    send_tick(1'b1, 1'b1, 1'b0, 20'd0);
    send_tick(1'b1, 1'b1, 1'b0, 20'd0);
    send_tick(1'b0, 1'b1, 1'b0, 20'd0);
    send_tick(1'b1, 1'b1, 1'b1, 20'd7);
    send_tick(1'b1, 1'b1, 1'b0, 20'd0);
    send_tick(1'b0, 1'b1, 1'b0, 20'd0);
    send_tick(1'b1, 1'b1, 1'b0, 20'd0);
    // reset wins over edge and entry
    send_tick(1'b0, 1'b0, 1'b1, 20'd1);
    send_tick(1'b1, 1'b1, 1'b1, 20'd999999);
    send_tick(1'b1, 1'b1, 1'b0, 20'd0);
    send_tick(1'b1, 1'b0, 1'b1, 20'd1);
    send_tick(1'b1, 1'b1, 1'b1, 20'h55555);
    send_tick(1'b1, 1'b0, 1'b0, 20'd0);
    send_tick(1'b1, 1'b1, 1'b1, 20'hAAAAA);
    send_tick(1'b1, 1'b0, 1'b0, 20'd0);

    base = words_sent;
    while (words_sent < base + TICK_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_tick(1'b1, 1'b1, 1'b0, 20'd0);
          repeat ($urandom_range(1, 3))
            send_tick(1'b0, 1'b1, 1'($urandom_range(0, 1)), rand_entry());
          repeat ($urandom_range(0, 3)) begin
            repeat ($urandom_range(1, 25))
              send_tick(1'b1, 1'b1, 1'($urandom_range(0, 1)), rand_entry());
            repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'b1, 1'b0, 20'd0);
          end
          repeat ($urandom_range(1, 25)) send_tick(1'b1, 1'b1, 1'b0, 20'd0);
          if ($urandom_range(0, 3) != 0)
            send_tick(1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)),
                      rand_entry());
        end
        4, 5, 6: begin
          send_tick(1'b1, 1'b1, 1'b1, rand_entry());
          repeat ($urandom_range(1, 6))
            send_tick($urandom_range(0, 3) != 0, 1'b1, 1'($urandom_range(0, 1)),
                      rand_entry());
          if ($urandom_range(0, 1) != 0) send_tick(1'b1, 1'b0, 1'b0, 20'd0);
        end
        default: begin
          repeat ($urandom_range(1, 8))
            send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0,
                      1'($urandom_range(0, 1)), 20'($urandom));
        end
      endcase
    end
    in_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.n_errors == 0) begin
      $display("PASS stopwatch_and_countdown_timer");
    end else begin
      $display("FAIL stopwatch_and_countdown_timer");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/swcd_pkg.sv
sv/swcd_decode.sv
sv/swcd_core.sv
sv/stopwatch_and_countdown_timer.sv
dv/stopwatch_and_countdown_timer_tb.sv
